[rtl/vha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_pkg
// Shared widths, codes, controller states and command/status bundles for the
// voxel histogram accumulator.
// ----------------------------------------------------------------------------
package vha_pkg;

   localparam int SIZE_X_DEF             = 16;
   localparam int SIZE_Y_DEF             = 16;
   localparam int SIZE_Z_DEF             = 16;
   localparam int MAX_SUBDIVIDE_LOG2_DEF = 3;

   localparam int MODE_W    = 2;
   localparam int COORD_W   = 32;
   localparam int ACC_W     = 48;
   localparam int LANDED_W  = 10;
   localparam int TOTAL_W   = 32;
   localparam int LG_W      = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;

   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB_ADD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PREDICT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBDIV_LOG2 = 3'd6;

   localparam logic [COORD_W-1:0] INV_WIDTH_RESET = 32'h0001_0000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_LOOKUP,
      ST_READ,
      ST_WRITE,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic clr_step;
      logic load_item;
      logic mul;
      logic lookup;
      logic read;
      logic write;
      logic next_sub;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_predict;
      logic is_nop;
      logic hit;
      logic last_sub;
      logic rsp_busy;
   } dp_status_type;

endpackage

[rtl/vha_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_req_if
// Input channel: one point word per handshake.
// ----------------------------------------------------------------------------
interface vha_req_if import vha_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic signed [COORD_W-1:0]  coord_x;
   logic signed [COORD_W-1:0]  coord_y;
   logic signed [COORD_W-1:0]  coord_z;
   logic signed [COORD_W-1:0]  weight;

   modport source (output valid, mode, coord_x, coord_y, coord_z, weight, input ready);
   modport sink   (input valid, mode, coord_x, coord_y, coord_z, weight, output ready);
endinterface

[rtl/vha_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_rsp_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface vha_rsp_if import vha_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ACC_W-1:0]  bin_value;
   logic                     in_range;
   logic [LANDED_W-1:0]      landed;
   logic [TOTAL_W-1:0]       total_count;

   modport source (output valid, bin_value, in_range, landed, total_count, input ready);
   modport sink   (input valid, bin_value, in_range, landed, total_count, output ready);
endinterface

[rtl/vha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_ctrl
// Sequencer: clearing pass, item load, axis multiply, per-subpoint lookup / read / write,
// result hand-off.
// ----------------------------------------------------------------------------
module vha_ctrl import vha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = status.is_nop ? ST_RESP : ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (status.hit) begin
               state_in = status.is_predict ? ST_RESP : ST_WRITE;
            end else begin
               state_in = (status.is_predict || status.last_sub) ? ST_RESP : ST_LOOKUP;
            end
         end
         ST_WRITE: begin
            state_in = status.last_sub ? ST_RESP : ST_LOOKUP;
         end
         ST_RESP: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_READ: begin
            cmd.read     = status.hit;
            cmd.next_sub = !status.hit && !status.is_predict && !status.last_sub;
         end
         ST_WRITE: begin
            cmd.write    = 1'b1;
            cmd.next_sub = !status.last_sub;
         end
         ST_RESP: begin
            cmd.load_rsp = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/vha_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_dp
// Datapath: control registers, axis multipliers, subpoint lattice, bin address, clearing
// pass, bin memory with saturating accumulate, totals and the result register.
// ----------------------------------------------------------------------------
module vha_dp import vha_pkg::*; #(
   parameter int SIZE_X             = SIZE_X_DEF,
   parameter int SIZE_Y             = SIZE_Y_DEF,
   parameter int SIZE_Z             = SIZE_Z_DEF,
   parameter int MAX_SUBDIVIDE_LOG2 = MAX_SUBDIVIDE_LOG2_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [MODE_W-1:0]         mode,
   input  logic signed [COORD_W-1:0] coord_x,
   input  logic signed [COORD_W-1:0] coord_y,
   input  logic signed [COORD_W-1:0] coord_z,
   input  logic signed [COORD_W-1:0] weight,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [ACC_W-1:0]   rsp_bin_value,
   output logic                      rsp_in_range,
   output logic [LANDED_W-1:0]       rsp_landed,
   output logic [TOTAL_W-1:0]        rsp_total_count
);

   localparam int DEPTH  = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW     = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
   localparam int YW     = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
   localparam int ZW     = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
   localparam int SUBW   = (MAX_SUBDIVIDE_LOG2 <= 1) ? 1 :
                           ((MAX_SUBDIVIDE_LOG2 > 3) ? 3 : MAX_SUBDIVIDE_LOG2);
   localparam int PROD_W = 66;
   localparam int IDX_W  = 34;
   localparam int T_W    = COORD_W + 1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [ADDR_W-1:0]       CLR_LAST = ADDR_W'(DEPTH - 1);

   // control registers
   logic signed [COORD_W-1:0] lower_x_ff, lower_y_ff, lower_z_ff;
   logic [COORD_W-1:0]        inv_x_ff, inv_y_ff, inv_z_ff;
   logic [LG_W-1:0]           subdiv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_x_ff <= '0;
         lower_y_ff <= '0;
         lower_z_ff <= '0;
         inv_x_ff   <= INV_WIDTH_RESET;
         inv_y_ff   <= INV_WIDTH_RESET;
         inv_z_ff   <= INV_WIDTH_RESET;
         subdiv_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOWER_X:     lower_x_ff <= csr_wdata;
            CSR_LOWER_Y:     lower_y_ff <= csr_wdata;
            CSR_LOWER_Z:     lower_z_ff <= csr_wdata;
            CSR_INV_WIDTH_X: inv_x_ff   <= csr_wdata;
            CSR_INV_WIDTH_Y: inv_y_ff   <= csr_wdata;
            CSR_INV_WIDTH_Z: inv_z_ff   <= csr_wdata;
            CSR_SUBDIV_LOG2: subdiv_ff  <= csr_wdata[LG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // item registers
   logic [MODE_W-1:0]         mode_ff;
   logic [LG_W-1:0]           lg_ff, lg_in;
   logic signed [T_W-1:0]     tx_ff, ty_ff, tz_ff;
   logic signed [COORD_W-1:0] sw_ff, sw_in;
   logic [3:0]                wshift;

   always_comb begin
      lg_in = '0;
      if (mode == MODE_SUB_ADD) begin
         lg_in = ({1'b0, subdiv_ff} > 3'(MAX_SUBDIVIDE_LOG2)) ?
                 LG_W'(MAX_SUBDIVIDE_LOG2) : subdiv_ff;
      end
      wshift = (4'(lg_in) << 1) + 4'(lg_in);
      sw_in  = weight >>> wshift;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff <= mode;
         lg_ff   <= lg_in;
         sw_ff   <= sw_in;
         tx_ff   <= T_W'(coord_x) - T_W'(lower_x_ff);
         ty_ff   <= T_W'(coord_y) - T_W'(lower_y_ff);
         tz_ff   <= T_W'(coord_z) - T_W'(lower_z_ff);
      end
   end

   // axis products
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         px_ff <= tx_ff * $signed({1'b0, inv_x_ff});
         py_ff <= ty_ff * $signed({1'b0, inv_y_ff});
         pz_ff <= tz_ff * $signed({1'b0, inv_z_ff});
      end
   end

   // subpoint lattice counters
   logic [SUBW-1:0] si_ff, sj_ff, sk_ff;
   logic [SUBW-1:0] smask;
   logic [4:0]      offshift;
   logic            last_sub;

   assign smask    = SUBW'((4'd1 << lg_ff) - 4'd1);
   assign offshift = 5'd31 - 5'(lg_ff);
   assign last_sub = (si_ff == smask) && (sj_ff == smask) && (sk_ff == smask);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         si_ff <= '0;
         sj_ff <= '0;
         sk_ff <= '0;
      end else if (cmd.next_sub) begin
         if (sk_ff == smask) begin
            sk_ff <= '0;
            if (sj_ff == smask) begin
               sj_ff <= '0;
               si_ff <= si_ff + 1'b1;
            end else begin
               sj_ff <= sj_ff + 1'b1;
            end
         end else begin
            sk_ff <= sk_ff + 1'b1;
         end
      end
   end

   function automatic logic signed [IDX_W-1:0] axis_off(input logic [SUBW-1:0] pos,
                                                        input logic [4:0] sh);
      logic [IDX_W-1:0] odd;
      begin
         odd      = IDX_W'({pos, 1'b1}) << sh;
         axis_off = $signed(odd) - $signed(IDX_W'(34'h0_8000_0000));
      end
   endfunction

   // bin lookup
   logic signed [PROD_W-1:0] sx, sy, sz;
   logic signed [IDX_W-1:0]  ix, iy, iz;
   logic                     hit_in, hit_ff;
   logic [ADDR_W-1:0]        addr_in, addr_ff;

   always_comb begin
      sx = px_ff + PROD_W'(axis_off(si_ff, offshift));
      sy = py_ff + PROD_W'(axis_off(sj_ff, offshift));
      sz = pz_ff + PROD_W'(axis_off(sk_ff, offshift));
      ix = sx[PROD_W-1:32];
      iy = sy[PROD_W-1:32];
      iz = sz[PROD_W-1:32];
      hit_in = !ix[IDX_W-1] && (ix[IDX_W-2:0] < (IDX_W-1)'(SIZE_X)) &&
               !iy[IDX_W-1] && (iy[IDX_W-2:0] < (IDX_W-1)'(SIZE_Y)) &&
               !iz[IDX_W-1] && (iz[IDX_W-2:0] < (IDX_W-1)'(SIZE_Z));
      addr_in = ADDR_W'(ix[XW-1:0]) + ADDR_W'(SIZE_X) *
                (ADDR_W'(iy[YW-1:0]) + ADDR_W'(SIZE_Y) * ADDR_W'(iz[ZW-1:0]));
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff  <= hit_in;
         addr_ff <= addr_in;
      end
   end

   // clearing pass
   logic [ADDR_W-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // bin memory and saturating accumulate
   logic [ACC_W-1:0]        mem [DEPTH];
   logic signed [ACC_W-1:0] rd_ff;
   logic signed [ACC_W:0]   acc_sum;
   logic signed [ACC_W-1:0] acc_sat;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_wa;
   logic [ACC_W-1:0]        mem_wd;

   always_comb begin
      acc_sum = (ACC_W+1)'(rd_ff) + (ACC_W+1)'(sw_ff);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
      mem_we = cmd.clr_step || cmd.write;
      mem_wa = cmd.clr_step ? clr_ff : addr_ff;
      mem_wd = cmd.clr_step ? '0 : acc_sat;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.read) begin
         rd_ff <= mem[addr_ff];
      end
   end

   // per-item and running totals
   logic [TOTAL_W-1:0]  hit_count_ff;
   logic [LANDED_W-1:0] landed_ff;
   logic                inr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff <= '0;
      end else if (cmd.write && (hit_count_ff != '1)) begin
         hit_count_ff <= hit_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         landed_ff <= '0;
         inr_ff    <= 1'b0;
      end else begin
         if (cmd.write) landed_ff <= landed_ff + 1'b1;
         if (cmd.read)  inr_ff    <= 1'b1;
      end
   end

   // result register
   logic                    rsp_valid_ff;
   logic signed [ACC_W-1:0] rsp_value_ff;
   logic                    rsp_inr_ff;
   logic [LANDED_W-1:0]     rsp_landed_ff;
   logic [TOTAL_W-1:0]      rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_value_ff  <= ((mode_ff == MODE_PREDICT) && inr_ff) ? rd_ff : '0;
         rsp_inr_ff    <= inr_ff;
         rsp_landed_ff <= landed_ff;
         rsp_total_ff  <= hit_count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_value   = rsp_value_ff;
   assign rsp_in_range    = rsp_inr_ff;
   assign rsp_landed      = rsp_landed_ff;
   assign rsp_total_count = rsp_total_ff;

   assign status.clr_last   = (clr_ff == CLR_LAST);
   assign status.is_predict = (mode_ff == MODE_PREDICT);
   assign status.is_nop     = (mode_ff == MODE_NOP);
   assign status.hit        = hit_ff;
   assign status.last_sub   = last_sub;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

[rtl/voxel_histogram_accumulator.sv]
`timescale 1ns / 1ps
// Sequence: an accepted item passes the multiply, lookup and read states, a write on an
//   add that hits, then the response state; a subdivided add repeats lookup, read and
//   write per subpoint (no write outside the box); the unused mode skips to the response.
// Throughput: one item at a time; the input is ready again once its result is registered,
//   which waits while an earlier result is untaken. Reset: synchronous; a clearing pass
//   zeroes all SIZE_X*SIZE_Y*SIZE_Z bins (4096 by default); no word is accepted until it ends.
// ----------------------------------------------------------------------------
// voxel_histogram_accumulator
// Bins Q16.16 points into a 3-D voxel grid with saturating accumulate,
// subdivided add and predict read.
// ----------------------------------------------------------------------------
module voxel_histogram_accumulator import vha_pkg::*; #(
   parameter int SIZE_X             = SIZE_X_DEF,
   parameter int SIZE_Y             = SIZE_Y_DEF,
   parameter int SIZE_Z             = SIZE_Z_DEF,
   parameter int MAX_SUBDIVIDE_LOG2 = MAX_SUBDIVIDE_LOG2_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   vha_req_if.sink              req_chan,
   vha_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   vha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vha_dp #(
      .SIZE_X             (SIZE_X),
      .SIZE_Y             (SIZE_Y),
      .SIZE_Z             (SIZE_Z),
      .MAX_SUBDIVIDE_LOG2 (MAX_SUBDIVIDE_LOG2)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .mode            (req_chan.mode),
      .coord_x         (req_chan.coord_x),
      .coord_y         (req_chan.coord_y),
      .coord_z         (req_chan.coord_z),
      .weight          (req_chan.weight),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_bin_value   (rsp_chan.bin_value),
      .rsp_in_range    (rsp_chan.in_range),
      .rsp_landed      (rsp_chan.landed),
      .rsp_total_count (rsp_chan.total_count)
   );

endmodule

[tb/sv/tb_voxel_histogram_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_histogram_accumulator
// Drives point words into the voxel histogram accumulator and scores every
// result word against an in-bench copy of the bin store and hit counter, or
// against a hand-written tally for the typed rows of the directed script.
// A short directed script covers the box edges, the weight extremes, the
// subdivided lattice, zero and extreme inverse widths and the unused mode.
// Randomized phases under several box settings follow, with bursts of idle and stall cycles on both channels.
// ----------------------------------------------------------------------------
module tb_voxel_histogram_accumulator;
   import vha_pkg::*;

   localparam int NBINS       = SIZE_X_DEF * SIZE_Y_DEF * SIZE_Z_DEF;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 8;
   localparam logic [COORD_W-1:0] ONE = 32'h0001_0000;
   localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] w;
   } point_t;

   typedef struct packed {
      logic signed [ACC_W-1:0] bin_value;
      logic                    in_range;
      logic [LANDED_W-1:0]     landed;
      logic [TOTAL_W-1:0]      total_count;
   } tally_t;

   typedef enum bit {ROW_POINT, ROW_REG} row_kind_t;

   typedef struct {
      row_kind_t              kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [CSR_W-1:0]       reg_val;
      point_t                 pt;
      bit                     typed;
      tally_t                 want;
   } plan_row_t;

   typedef struct {
      logic [2:0][COORD_W-1:0] lo;
      logic [2:0][COORD_W-1:0] inv;
      logic [LG_W-1:0]         lg;
   } box_cfg_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LOWER_X;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 take = 1'b0;

   vha_req_if req_chan();
   vha_rsp_if rsp_chan();

   assign rsp_chan.ready = take;

   voxel_histogram_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic signed [ACC_W-1:0]   voxel_mem [NBINS];
   logic [TOTAL_W-1:0]        hits_seen;
   logic signed [COORD_W-1:0] box_lo [3];
   logic [COORD_W-1:0]        bin_scale [3];
   logic [LG_W-1:0]           split_lg;

   tally_t    owed_tallies [$];
   point_t    lately [$];
   plan_row_t plan [$];
   bit        idle_on = 1'b1;
   int        mismatches = 0;
   int        quiet_cycles = 0;
   int        stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void model_reset();
      foreach (voxel_mem[i]) voxel_mem[i] = '0;
      hits_seen = '0;
      for (int a = 0; a < 3; a++) begin
         box_lo[a]    = '0;
         bin_scale[a] = INV_WIDTH_RESET;
      end
      split_lg = '0;
   endfunction

   function automatic void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      case (idx)
         CSR_LOWER_X:     box_lo[0] = val;
         CSR_LOWER_Y:     box_lo[1] = val;
         CSR_LOWER_Z:     box_lo[2] = val;
         CSR_INV_WIDTH_X: bin_scale[0] = val;
         CSR_INV_WIDTH_Y: bin_scale[1] = val;
         CSR_INV_WIDTH_Z: bin_scale[2] = val;
         CSR_SUBDIV_LOG2: split_lg = val[LG_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic longint axis_bin(logic signed [COORD_W+1:0] t, logic [COORD_W-1:0] inv,
                                       longint off);
      logic signed [79:0] acc;
      acc = t * $signed({1'b0, inv}) + off;
      return longint'(acc >>> 32);
   endfunction

   function automatic bit locate_bin(input logic signed [COORD_W+1:0] tx, ty, tz,
                                     input longint ox, oy, oz, output int addr);
      longint ix, iy, iz;
      ix = axis_bin(tx, bin_scale[0], ox);
      iy = axis_bin(ty, bin_scale[1], oy);
      iz = axis_bin(tz, bin_scale[2], oz);
      addr = 0;
      if (ix < 0 || ix >= SIZE_X_DEF || iy < 0 || iy >= SIZE_Y_DEF || iz < 0 || iz >= SIZE_Z_DEF)
         return 1'b0;
      addr = int'(ix + SIZE_X_DEF * (iy + SIZE_Y_DEF * iz));
      return 1'b1;
   endfunction

   function automatic void deposit(int a, longint v);
      longint sum;
      sum = longint'(voxel_mem[a]) + v;
      if (sum > ACC_HI) sum = ACC_HI;
      else if (sum < ACC_LO) sum = ACC_LO;
      voxel_mem[a] = ACC_W'(sum);
      if (hits_seen != '1) hits_seen = hits_seen + 1;
   endfunction

   function automatic tally_t voxel_apply(point_t p);
      logic signed [COORD_W+1:0] tx, ty, tz;
      longint sw, step;
      int lg, s, addr;
      tally_t r;
      r = '0;
      tx = p.x - box_lo[0];
      ty = p.y - box_lo[1];
      tz = p.z - box_lo[2];
      case (p.mode)
         MODE_ADD: begin
            if (locate_bin(tx, ty, tz, 0, 0, 0, addr)) begin
               deposit(addr, longint'(p.w));
               r.in_range = 1'b1;
               r.landed   = 1;
            end
         end
         MODE_SUB_ADD: begin
            lg   = (split_lg > MAX_SUBDIVIDE_LOG2_DEF) ? MAX_SUBDIVIDE_LOG2_DEF : int'(split_lg);
            s    = 1 << lg;
            step = longint'(1) <<< (31 - lg);
            sw   = longint'(p.w) >>> (3 * lg);
            for (int i = 0; i < s; i++)
               for (int j = 0; j < s; j++)
                  for (int k = 0; k < s; k++)
                     if (locate_bin(tx, ty, tz, longint'(2 * i + 1 - s) * step,
                                    longint'(2 * j + 1 - s) * step,
                                    longint'(2 * k + 1 - s) * step, addr)) begin
                        deposit(addr, sw);
                        r.in_range = 1'b1;
                        r.landed   = r.landed + 1;
                     end
         end
         MODE_PREDICT: begin
            if (locate_bin(tx, ty, tz, 0, 0, 0, addr)) begin
               r.bin_value = voxel_mem[addr];
               r.in_range  = 1'b1;
            end
         end
         default: ;
      endcase
      r.total_count = hits_seen;
      return r;
   endfunction

   function automatic tally_t tally(longint bv, bit ir, int ld, longint tc);
      tally_t r;
      r.bin_value   = ACC_W'(bv);
      r.in_range    = ir;
      r.landed      = LANDED_W'(ld);
      r.total_count = TOTAL_W'(tc);
      return r;
   endfunction

   function automatic void plan_point(logic [MODE_W-1:0] m, logic [COORD_W-1:0] x, y, z, w,
                                      bit typed = 1'b0, tally_t want = '0);
      plan_row_t row;
      row.kind = ROW_POINT;
      row.reg_idx = CSR_LOWER_X;
      row.reg_val = '0;
      row.pt = '{m, x, y, z, w};
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endfunction

   function automatic void plan_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      plan_row_t row;
      row.kind = ROW_REG;
      row.reg_idx = idx;
      row.reg_val = val;
      row.pt = '0;
      row.typed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   function automatic void plan_directed();
      plan_point(MODE_PREDICT, 0, 0, 0, 0, 1, tally(0, 1, 0, 0));
      plan_point(MODE_ADD, 0, 0, 0, 32'h7FFF_FFFF, 1, tally(0, 1, 1, 1));
      plan_point(MODE_PREDICT, 0, 0, 0, 0, 1, tally(48'h0000_7FFF_FFFF, 1, 0, 1));
      plan_point(MODE_ADD, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 32'h8000_0000,
                 1, tally(0, 1, 1, 2));
      plan_point(MODE_PREDICT, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 0,
                 1, tally(48'hFFFF_8000_0000, 1, 0, 2));
      plan_point(MODE_ADD, 32'h0010_0000, 0, 0, 1, 1, tally(0, 0, 0, 2));
      plan_point(MODE_ADD, 32'hFFFF_FFFF, 0, 0, 1, 1, tally(0, 0, 0, 2));
      plan_point(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                 1, tally(0, 0, 0, 2));
      plan_point(MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                 1, tally(0, 0, 0, 2));
      plan_point(MODE_NOP, 0, 0, 0, 32'hFFFF_FFFF, 1, tally(0, 0, 0, 2));
      plan_point(MODE_SUB_ADD, ONE, ONE, ONE, 5, 1, tally(0, 1, 1, 3));
      plan_point(MODE_PREDICT, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 0,
                 1, tally(5, 1, 0, 3));
      plan_point(MODE_PREDICT, 0, 32'hFFFF_0000, 0, 0, 1, tally(0, 0, 0, 3));
      plan_reg(CSR_SUBDIV_LOG2, 1);
      plan_point(MODE_SUB_ADD, 0, 0, 0, 32'hFFFF_FFF9);
      plan_point(MODE_SUB_ADD, 32'h0008_0000, 32'h0008_0000, 32'h0008_0000, 32'h7FFF_FFFF);
      plan_point(MODE_PREDICT, 32'h0008_4000, 32'h0008_4000, 32'h0008_4000, 0);
      plan_reg(CSR_SUBDIV_LOG2, 3);
      plan_point(MODE_SUB_ADD, 32'h000F_F000, 32'h000F_F000, 32'h000F_F000, 32'h8000_0000);
      plan_point(MODE_SUB_ADD, 32'h0008_0000, 32'h0008_0000, 32'h0008_0000, 32'hFFFF_FFFF);
      plan_point(MODE_PREDICT, 32'h0008_1000, 32'h0008_1000, 32'h0008_1000, 0);
      plan_reg(CSR_INV_WIDTH_X, 0);
      plan_point(MODE_ADD, 32'h7FFF_FFFF, 32'h0003_0000, 32'h0003_0000, 32'h0001_2345);
      plan_point(MODE_PREDICT, 32'h8000_0000, 32'h0003_0000, 32'h0003_0000, 0);
      plan_reg(CSR_INV_WIDTH_X, 32'hFFFF_FFFF);
      plan_point(MODE_ADD, 32'h0000_0010, 32'h0003_0000, 32'h0003_0000, 32'h0000_0777);
      plan_reg(CSR_INV_WIDTH_X, 1);
      plan_point(MODE_ADD, 32'h7FFF_FFFF, 32'h0004_0000, 32'h0004_0000, 32'hFFFF_0000);
   endfunction

   function automatic logic [COORD_W-1:0] aim_axis(logic [COORD_W-1:0] lo,
                                                   logic [COORD_W-1:0] inv);
      logic signed [79:0] goal;
      if (inv == 0) return $urandom;
      goal = longint'($urandom_range(0, 21)) - 3;
      goal = (goal <<< 32) + $signed({48'd0, $urandom});
      goal = goal / $signed({48'd0, inv});
      return lo + goal[COORD_W-1:0];
   endfunction

   function automatic point_t scatter_point();
      point_t p;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         p.mode = MODE_W'($urandom);
         p.x = $urandom;
         p.y = $urandom;
         p.z = $urandom;
         p.w = $urandom;
         return p;
      end
      if (pick < 25 && lately.size() != 0) begin
         p = lately[$urandom_range(0, lately.size() - 1)];
         p.mode = ($urandom_range(0, 2) == 0) ? MODE_ADD : MODE_PREDICT;
         p.w = $urandom;
         return p;
      end
      pick = $urandom_range(0, 19);
      p.mode = (pick < 8) ? MODE_ADD : (pick < 13) ? MODE_SUB_ADD :
               (pick < 19) ? MODE_PREDICT : MODE_NOP;
      p.x = aim_axis(box_lo[0], bin_scale[0]);
      p.y = aim_axis(box_lo[1], bin_scale[1]);
      p.z = aim_axis(box_lo[2], bin_scale[2]);
      case ($urandom_range(0, 9))
         0:       p.w = 32'h7FFF_FFFF;
         1:       p.w = 32'h8000_0000;
         2:       p.w = $urandom_range(0, 255) - 128;
         default: p.w = $urandom;
      endcase
      return p;
   endfunction

   function automatic box_cfg_t phase_setup(int ph);
      box_cfg_t c;
      for (int a = 0; a < 3; a++) begin
         c.lo[a]  = '0;
         c.inv[a] = INV_WIDTH_RESET;
      end
      c.lg = '0;
      case (ph)
         1: begin
            for (int a = 0; a < 3; a++) begin
               c.lo[a]  = 32'hFFF8_0000;
               c.inv[a] = 32'h0002_0000;
            end
            c.lg = 1;
         end
         2: begin
            for (int a = 0; a < 3; a++) begin
               c.lo[a]  = 32'hFFE0_0000 + $urandom_range(0, 32'h0020_0000);
               c.inv[a] = $urandom_range(32'h0000_2000, 32'h0004_0000);
            end
            c.lg = 2;
         end
         3: begin
            c.lo  = {32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
            c.inv = {32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001};
            c.lg  = 3;
         end
         4: begin
            c.lo  = {32'($urandom), 32'hFFFF_0000, 32'h0000_0000};
            c.inv = {32'h0000_0000, 32'h0001_0000, 32'h0001_0000};
            c.lg  = 3;
         end
         5: begin
            for (int a = 0; a < 3; a++) begin
               c.lo[a]  = $urandom;
               c.inv[a] = ($urandom_range(0, 1) != 0) ? $urandom
                                                       : $urandom_range(1, 32'h0008_0000);
            end
            c.lg = LG_W'($urandom_range(0, 3));
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (owed_tallies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_box(box_cfg_t c);
      drain();
      write_reg(CSR_LOWER_X, c.lo[0]);
      write_reg(CSR_LOWER_Y, c.lo[1]);
      write_reg(CSR_LOWER_Z, c.lo[2]);
      write_reg(CSR_INV_WIDTH_X, c.inv[0]);
      write_reg(CSR_INV_WIDTH_Y, c.inv[1]);
      write_reg(CSR_INV_WIDTH_Z, c.inv[2]);
      write_reg(CSR_SUBDIV_LOG2, CSR_W'(c.lg));
      csr_we <= 1'b0;
   endtask

   task automatic send_point(point_t p, bit typed = 1'b0, tally_t want = '0);
      int gap;
      tally_t r;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.mode    <= p.mode;
      req_chan.coord_x <= p.x;
      req_chan.coord_y <= p.y;
      req_chan.coord_z <= p.z;
      req_chan.weight  <= p.w;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      r = voxel_apply(p);
      if (p.mode == MODE_ADD && r.in_range) begin
         lately.push_back(p);
         if (lately.size() > 24) void'(lately.pop_front());
      end
      owed_tallies.push_back(typed ? want : r);
   endtask

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tally_t got;
      tally_t want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
         got = '{rsp_chan.bin_value, rsp_chan.in_range, rsp_chan.landed, rsp_chan.total_count};
         if (owed_tallies.size() == 0) begin
            $display("%0t: result word with none owed, expected nothing actual %h", $time, got);
            mismatches++;
         end else begin
            want = owed_tallies.pop_front();
            compare_field("bin_value", 64'(want.bin_value), 64'(got.bin_value));
            compare_field("in_range", 64'(want.in_range), 64'(got.in_range));
            compare_field("landed", 64'(want.landed), 64'(got.landed));
            compare_field("total_count", 64'(want.total_count), 64'(got.total_count));
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         take <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         take <= 1'b0;
      end else begin
         take <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.mode    <= MODE_NOP;
      req_chan.coord_x <= '0;
      req_chan.coord_y <= '0;
      req_chan.coord_z <= '0;
      req_chan.weight  <= '0;
      model_reset();
      plan_directed();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[n]) begin
         if (plan[n].kind == ROW_REG) begin
            drain();
            write_reg(plan[n].reg_idx, plan[n].reg_val);
            csr_we <= 1'b0;
         end else begin
            send_point(plan[n].pt, plan[n].typed, plan[n].want);
         end
      end

      for (int ph = 1; ph <= 6; ph++) begin
         load_box(phase_setup(ph));
         idle_on = (ph != 6);
         for (int n = 0; n < ((ph == 3) ? 100 : 150); n++) begin
            if (ph != 6 && n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_point(scatter_point());
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/vha_pkg.sv
rtl/vha_req_if.sv
rtl/vha_rsp_if.sv
rtl/vha_ctrl.sv
rtl/vha_dp.sv
rtl/voxel_histogram_accumulator.sv
tb/sv/tb_voxel_histogram_accumulator.sv
